// ===== hdl/gpd_pkg.sv =====
package gpd_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned WordW    = 16;
  localparam int unsigned PosW     = 3;
  localparam int unsigned PayloadN = 5;
  localparam int unsigned PayIdxW  = 3;

  localparam logic [ByteW-1:0] HdrByte  = 8'hFF;
  localparam logic [WordW-1:0] CsumBias = 16'hFFFF;

  localparam logic [PosW-1:0] PosHunt  = 3'd0;
  localparam logic [PosW-1:0] PosHdr2  = 3'd1;
  localparam logic [PosW-1:0] PosFirst = 3'd2;
  localparam logic [PosW-1:0] PosLast  = 3'd7;

  localparam logic StatusOk  = 1'b0;
  localparam logic StatusBad = 1'b1;

endpackage

// ===== hdl/gyro_packet_deframer.sv =====
// gyro packet deframer
// input stream: one serial byte per transaction on s_axis_tdata
// packets are two 0xff header bytes, then rate, angle and checksum, each
// a little-endian 16-bit word; the checksum must equal 0xffff + rate + angle
// a wrong second header byte drops that byte and hunting restarts
// output stream: one transaction per packet, rate in tdata[15:0], angle in
// tdata[31:16], tuser = 1 on a checksum mismatch (values still delivered)
// the result register is loaded as the eighth byte is accepted
// throughput: one byte per cycle unless a full output register is stalled;
// framing and the 16-bit checksum add and compare feed the result register
// when the receiver stalls, a result waits in the output register and
// input is held off only while that register is full and not being taken
// reset clears the framing state to hunting and empties the output register
module gyro_packet_deframer
  import gpd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] rate_value, [31:16] angle_value
  output logic        m_axis_tuser    // [0] status
);

  logic [PosW-1:0]  pos_q, pos_d;
  logic [ByteW-1:0] held_q [PayloadN];
  logic             out_valid_q, out_valid_d;
  logic [WordW-1:0] rate_q, angle_q;
  logic             status_q;
  logic             in_acc;
  logic             last_byte;
  logic [WordW-1:0] rate_w, angle_w, got_w, expect_w;
  logic [PayIdxW-1:0] wr_idx;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign last_byte     = (pos_q == PosLast);
  assign wr_idx        = PayIdxW'(pos_q - PosFirst);

  assign rate_w   = {held_q[1], held_q[0]};
  assign angle_w  = {held_q[3], held_q[2]};
  assign got_w    = {s_axis_tdata, held_q[4]};
  assign expect_w = CsumBias + rate_w + angle_w;

  always_comb begin
    pos_d = pos_q;
    if (in_acc) begin
      if (pos_q == PosHunt) begin
        pos_d = (s_axis_tdata == HdrByte) ? PosHdr2 : PosHunt;
      end else if (pos_q == PosHdr2) begin
        pos_d = (s_axis_tdata == HdrByte) ? PosFirst : PosHunt;
      end else if (last_byte) begin
        pos_d = PosHunt;
      end else begin
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (in_acc && last_byte) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= PosHunt;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && pos_q != PosHunt && pos_q != PosHdr2 && !last_byte) begin
      held_q[wr_idx] <= s_axis_tdata;
    end
    if (in_acc && last_byte) begin
      rate_q   <= rate_w;
      angle_q  <= angle_w;
      status_q <= (expect_w == got_w) ? StatusOk : StatusBad;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {angle_q, rate_q};
  assign m_axis_tuser  = status_q;

endmodule

// ===== hdl/gpd_checker.sv =====
module gpd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // a stalled result holds its contents
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // input held off only while a result is stalled
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("input stalled without a pending result");

  // a new result follows an accepted byte
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("result without an input transaction");

  // a valid result carries known values
  a_out_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !$isunknown({m_axis_tdata, m_axis_tuser}))
    else $error("result with unknown contents");

endmodule

bind gyro_packet_deframer gpd_checker u_gpd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
